### design/rkc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkc_pkg
// Types, register indexes and arithmetic helpers for the RGB 3x3 convolution
// core.
// ----------------------------------------------------------------------------
package rkc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_COEF0  = 3'd2;
    localparam logic [2:0] CFG_COEF1  = 3'd3;
    localparam logic [2:0] CFG_COEF2  = 3'd4;

    // Register reset values.
    localparam logic [10:0] WIDTH_RESET  = 11'd1024;
    localparam logic [15:0] HEIGHT_RESET = 16'd768;

    typedef logic [23:0]        pix_t;
    typedef logic [47:0]        coef_group_t;
    typedef logic signed [15:0] coef_t;
    typedef logic signed [24:0] prod_t;
    typedef logic signed [27:0] sum_t;

    // Pick the signed Q8.8 entry for y offset l out of one coefficient group.
    function automatic coef_t coef_field(input coef_group_t grp, input logic [1:0] l);
        coef_t f;
        unique case (l)
            2'd0:    f = coef_t'(grp[15:0]);
            2'd1:    f = coef_t'(grp[31:16]);
            2'd2:    f = coef_t'(grp[47:32]);
            default: f = '0;
        endcase
        return f;
    endfunction

    // Floor the Q8.8 sum to an integer and clamp it to 0..255.
    function automatic logic [7:0] clamp_pix(input sum_t s);
        logic signed [19:0] t;
        logic [7:0]         r;
        t = 20'(s >>> 8);
        if (s < 0)
        begin
            r = 8'd0;
        end
        else if (t > 20'sd255)
        begin
            r = 8'd255;
        end
        else
        begin
            r = t[7:0];
        end
        return r;
    endfunction

endpackage

### design/rgb_kernel_convolution_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_core
// RGB 3x3 convolution over a raster-order pixel stream with two line buffers.
// ----------------------------------------------------------------------------
// One pixel transaction is accepted per clock while in_stall is low. Most
// pixels cause at most one result; at the right image edge and the last row a
// pixel causes up to three or nine results, which leave one per clock while
// out_stall is low, and the input stalls while they are issued. A pixel's
// line buffer read happens at the edge that accepts it, then come the window
// and position step, the products, and the sum and clamp, each registered.
// Pixels outside the image count as zero, coefficients are signed
// Q8.8 and each result is floored and clamped to 0..255. Writing the width or
// height restarts the frame at row zero, column zero.
module rgb_kernel_convolution_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [47:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          red_in,
    input  logic [7:0]          green_in,
    input  logic [7:0]          blue_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [9:0]          out_col,
    output logic [15:0]         out_row,
    output logic [7:0]          red_out,
    output logic [7:0]          green_out,
    output logic [7:0]          blue_out,
    output logic                run_last
);
    import rkc_pkg::*;

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int EW    = (WW > 11) ? WW : 11;
    localparam int AW    = $clog2(2 * MAX_WIDTH);
    localparam int DEPTH = 2 * MAX_WIDTH;

    // Configuration registers.
    logic [10:0]  width_reg;
    logic [15:0]  height_reg;
    coef_group_t  coef_reg [3];

    // Position counters.
    logic [CW-1:0] col_reg;
    logic [15:0]   row_reg;

    // Line buffers: two rows, selected by row parity.
    pix_t line_mem [DEPTH];

    // Input stage.
    logic          a_valid_reg;
    pix_t          a_pix_reg;
    pix_t          a_old_reg;
    pix_t          a_prev_reg;
    logic [CW-1:0] a_col_reg;
    logic [15:0]   a_row_reg;

    // Window and output sequencer stage.
    pix_t          win_reg [3][3];
    logic          b_valid_reg;
    logic [CW-1:0] b_col_reg;
    logic [15:0]   b_row_reg;
    logic [CW-1:0] b_i_reg;
    logic [CW-1:0] b_ilo_reg;
    logic [CW-1:0] b_ihi_reg;
    logic [15:0]   b_j_reg;
    logic [15:0]   b_jhi_reg;

    // Product stage.
    logic          p_valid_reg;
    logic [CW-1:0] p_col_reg;
    logic [15:0]   p_row_reg;
    logic          p_last_reg;
    prod_t         prod_reg [3][3][3];
    prod_t         prod_next [3][3][3];

    // Output register.
    logic          o_valid_reg;
    logic [CW-1:0] o_col_reg;
    logic [15:0]   o_row_reg;
    logic [7:0]    o_pix_reg [3];
    logic          o_last_reg;

    // Effective geometry.
    logic [EW-1:0] width_ext;
    logic [EW-1:0] width_eff;
    logic [CW-1:0] col_last;
    logic [15:0]   row_last;

    always_comb
    begin
        width_ext = EW'(width_reg);
        if (width_ext == '0)
        begin
            width_eff = EW'(1);
        end
        else if (width_ext > EW'(MAX_WIDTH))
        begin
            width_eff = EW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_ext;
        end
        col_last = CW'(width_eff - EW'(1));
        row_last = (height_reg == 16'd0) ? 16'd0 : height_reg - 16'd1;
    end

    // Handshake chain from the output register back to the input.
    logic o_ready, p_ready, b_fire, b_last, b_ready, a_move, a_ready, in_take;

    always_comb
    begin
        o_ready  = !o_valid_reg || !out_stall;
        p_ready  = !p_valid_reg || o_ready;
        b_fire   = b_valid_reg && p_ready;
        b_last   = (b_i_reg == b_ihi_reg) && (b_j_reg == b_jhi_reg);
        b_ready  = !b_valid_reg || (b_fire && b_last);
        a_move   = a_valid_reg && b_ready;
        a_ready  = !a_valid_reg || b_ready;
        in_take  = in_valid && a_ready;
        in_stall = !a_ready;
    end

    // Configuration writes; a geometry write restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            coef_reg[0] <= '0;
            coef_reg[1] <= '0;
            coef_reg[2] <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
        end
        else
        begin
            if (cfg_write && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT))
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (in_take)
            begin
                if (col_reg == col_last)
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == row_last) ? 16'd0 : row_reg + 16'd1;
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_WIDTH:  width_reg   <= cfg_data[10:0];
                    CFG_HEIGHT: height_reg  <= cfg_data[15:0];
                    CFG_COEF0:  coef_reg[0] <= cfg_data;
                    CFG_COEF1:  coef_reg[1] <= cfg_data;
                    CFG_COEF2:  coef_reg[2] <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    // Line buffer addresses for the row two back and the row one back.
    logic [AW-1:0] addr_old, addr_prev;
    pix_t          in_pix;

    always_comb
    begin
        addr_old  = row_reg[0] ? AW'(MAX_WIDTH) + AW'(col_reg) : AW'(col_reg);
        addr_prev = row_reg[0] ? AW'(col_reg) : AW'(MAX_WIDTH) + AW'(col_reg);
        in_pix    = {blue_in, green_in, red_in};
    end

    // Line buffer: the read of the overwritten slot returns its old content.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            line_mem[addr_old] <= in_pix;
            a_old_reg          <= line_mem[addr_old];
            a_prev_reg         <= line_mem[addr_prev];
            a_pix_reg          <= in_pix;
            a_col_reg          <= col_reg;
            a_row_reg          <= row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_move)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    // Range of output columns and rows that the incoming pixel completes.
    logic          have_i, have_j;
    logic [CW-1:0] ilo_next, ihi_next;
    logic [15:0]   jlo_next, jhi_next;

    always_comb
    begin
        have_i = 1'b1;
        have_j = 1'b1;
        if (a_col_reg == col_last)
        begin
            ilo_next = (a_col_reg >= CW'(2)) ? a_col_reg - CW'(2) : '0;
            ihi_next = a_col_reg;
        end
        else if (a_col_reg >= CW'(2))
        begin
            ilo_next = a_col_reg - CW'(2);
            ihi_next = ilo_next;
        end
        else
        begin
            have_i   = 1'b0;
            ilo_next = '0;
            ihi_next = '0;
        end
        if (a_row_reg == row_last)
        begin
            jlo_next = (a_row_reg >= 16'd2) ? a_row_reg - 16'd2 : 16'd0;
            jhi_next = a_row_reg;
        end
        else if (a_row_reg >= 16'd2)
        begin
            jlo_next = a_row_reg - 16'd2;
            jhi_next = jlo_next;
        end
        else
        begin
            have_j   = 1'b0;
            jlo_next = 16'd0;
            jhi_next = 16'd0;
        end
    end

    // Window shift and output sequencer payload.
    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            for (int y = 0; y < 3; y++)
            begin
                win_reg[y][0] <= win_reg[y][1];
                win_reg[y][1] <= win_reg[y][2];
            end
            win_reg[0][2] <= a_old_reg;
            win_reg[1][2] <= a_prev_reg;
            win_reg[2][2] <= a_pix_reg;
            b_col_reg     <= a_col_reg;
            b_row_reg     <= a_row_reg;
            b_i_reg       <= ilo_next;
            b_ilo_reg     <= ilo_next;
            b_ihi_reg     <= ihi_next;
            b_j_reg       <= jlo_next;
            b_jhi_reg     <= jhi_next;
        end
        else if (b_fire && !b_last)
        begin
            if (b_i_reg == b_ihi_reg)
            begin
                b_i_reg <= b_ilo_reg;
                b_j_reg <= b_j_reg + 16'd1;
            end
            else
            begin
                b_i_reg <= b_i_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (a_move)
        begin
            b_valid_reg <= have_i && have_j;
        end
        else if (b_fire && b_last)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    // Products: window cell (x,y) meets mask entry (x+di-2, y+dj-2), where
    // di and dj are the distances from the output pixel to the newest pixel.
    // Cells outside the mask are forced to zero so stale data never leaks in.
    logic [1:0] di, dj;

    always_comb
    begin
        logic [2:0] kx;
        logic [2:0] ly;
        coef_t      cf;
        pix_t       px;
        di = 2'(b_col_reg - b_i_reg);
        dj = 2'(b_row_reg - b_j_reg);
        for (int y = 0; y < 3; y++)
        begin
            for (int x = 0; x < 3; x++)
            begin
                kx = 3'(x) + 3'(di);
                ly = 3'(y) + 3'(dj);
                if (kx >= 3'd2 && ly >= 3'd2)
                begin
                    cf = coef_field(coef_reg[2'(kx - 3'd2)], 2'(ly - 3'd2));
                    px = win_reg[y][x];
                end
                else
                begin
                    cf = '0;
                    px = '0;
                end
                for (int ch = 0; ch < 3; ch++)
                begin
                    prod_next[y][x][ch] = prod_t'($signed({1'b0, px[8*ch +: 8]})
                                                  * cf);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            prod_reg   <= prod_next;
            p_col_reg  <= b_i_reg;
            p_row_reg  <= b_j_reg;
            p_last_reg <= b_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (p_ready)
        begin
            p_valid_reg <= b_fire;
        end
    end

    // Sum of the nine products per channel, floored and clamped.
    logic [7:0] pix_next [3];

    always_comb
    begin
        sum_t s;
        for (int ch = 0; ch < 3; ch++)
        begin
            s = '0;
            for (int y = 0; y < 3; y++)
            begin
                for (int x = 0; x < 3; x++)
                begin
                    s = s + sum_t'(prod_reg[y][x][ch]);
                end
            end
            pix_next[ch] = clamp_pix(s);
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_valid_reg && o_ready)
        begin
            o_col_reg  <= p_col_reg;
            o_row_reg  <= p_row_reg;
            o_pix_reg  <= pix_next;
            o_last_reg <= p_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_ready)
        begin
            o_valid_reg <= p_valid_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_col   = 10'(o_col_reg);
    assign out_row   = o_row_reg;
    assign red_out   = o_pix_reg[0];
    assign green_out = o_pix_reg[1];
    assign blue_out  = o_pix_reg[2];
    assign run_last  = o_last_reg;

endmodule

### design/rkc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkc_checker
// Port-level checks on the result channel of the RGB 3x3 convolution core.
// ----------------------------------------------------------------------------
module rkc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [9:0]  out_col,
    input logic [15:0] out_row,
    input logic [7:0]  red_out,
    input logic [7:0]  green_out,
    input logic [7:0]  blue_out,
    input logic        run_last
);

    // A stalled result transaction stays valid.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result valid dropped under stall");

    // A stalled result transaction keeps its payload.
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_col) && $stable(out_row)
            && $stable(red_out) && $stable(green_out) && $stable(blue_out)
            && $stable(run_last))
        else $error("result payload changed under stall");

    // The results of one pixel leave without a gap.
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_last |=> out_valid)
        else $error("gap inside a run of results");

    // Within a run, results advance in raster order.
    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_last |=>
            (out_row > $past(out_row))
            || (out_row == $past(out_row) && out_col > $past(out_col)))
        else $error("results of a run out of raster order");

endmodule

bind rgb_kernel_convolution_core rkc_checker u_rkc_checker (.*);

### tb/sv/rkc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkc_scoreboard
// Watches the pixel, result and register channels of the RGB 3x3
// convolution core. It predicts every filtered pixel from the accepted
// transactions and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module rkc_scoreboard #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [9:0]  out_col,
    input  logic [15:0] out_row,
    input  logic [7:0]  red_out,
    input  logic [7:0]  green_out,
    input  logic [7:0]  blue_out,
    input  logic        run_last,
    output int          errors,
    output int          pending
);
    import rkc_pkg::*;

    typedef struct packed {
        logic [9:0]  col;
        logic [15:0] row;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last;
    } filtered_pix_t;

    filtered_pix_t expected_pixels[$];

    // Shadow copy of the core state and registers.
    logic [10:0]  width_reg;
    logic [15:0]  height_reg;
    coef_group_t  coef_reg [3];
    pix_t         line_mem [2*MAX_WIDTH];
    pix_t         window   [9];
    int           col_pos;
    int           row_pos;
    int           pushed_count = 0;
    int           popped_count = 0;

    assign pending = pushed_count - popped_count;

    // Signed Q8.8 sum floored and limited to the pixel range.
    function automatic logic [7:0] saturate_q8(input int s);
        int t;
        if (s < 0)
        begin
            return 8'd0;
        end
        t = s >>> 8;
        return (t > 255) ? 8'd255 : t[7:0];
    endfunction

    // Step the window with one accepted pixel and queue the results it causes.
    task automatic filter_pixel(input pix_t pix);
        int w;
        int h;
        int c;
        int r;
        int i_lo;
        int i_hi;
        int j_lo;
        int j_hi;
        int so;
        int sp;
        int x;
        int y;
        int m;
        int s [3];
        pix_t v;
        filtered_pix_t e;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        c = col_pos;
        r = row_pos;
        so = (r % 2) * MAX_WIDTH + c;
        sp = ((r + 1) % 2) * MAX_WIDTH + c;
        for (int q = 0; q < 3; q++)
        begin
            window[q*3]   = window[q*3+1];
            window[q*3+1] = window[q*3+2];
        end
        window[2] = line_mem[so];
        window[5] = line_mem[sp];
        window[8] = pix;
        line_mem[so] = pix;
        if (c == w - 1)
        begin
            i_lo = (c >= 2) ? c - 2 : 0;
            i_hi = c;
        end
        else
        begin
            i_lo = c - 2;
            i_hi = c - 2;
        end
        if (r == h - 1)
        begin
            j_lo = (r >= 2) ? r - 2 : 0;
            j_hi = r;
        end
        else
        begin
            j_lo = r - 2;
            j_hi = r - 2;
        end
        if (i_lo >= 0 && j_lo >= 0)
        begin
            for (int j = j_lo; j <= j_hi; j++)
            begin
                for (int i = i_lo; i <= i_hi; i++)
                begin
                    s = '{0, 0, 0};
                    for (int k = 0; k < 3; k++)
                    begin
                        for (int l = 0; l < 3; l++)
                        begin
                            if (i + k <= c && j + l <= r)
                            begin
                                x = i + k + 2 - c;
                                y = j + l + 2 - r;
                                v = window[y*3 + x];
                                m = $signed(coef_reg[k][16*l +: 16]);
                                for (int ch = 0; ch < 3; ch++)
                                begin
                                    s[ch] += int'(v[8*ch +: 8]) * m;
                                end
                            end
                        end
                    end
                    e.col   = i[9:0];
                    e.row   = j[15:0];
                    e.red   = saturate_q8(s[0]);
                    e.green = saturate_q8(s[1]);
                    e.blue  = saturate_q8(s[2]);
                    e.last  = (i == i_hi) && (j == j_hi);
                    expected_pixels.push_back(e);
                    pushed_count++;
                end
            end
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
            begin
                r = 0;
            end
        end
        col_pos = c;
        row_pos = r;
    endtask

    // Register writes and pixel transactions update the shadow state.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            coef_reg   = '{default: '0};
            window     = '{default: '0};
            col_pos    = 0;
            row_pos    = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_WIDTH:
                    begin
                        width_reg = cfg_data[10:0];
                        col_pos   = 0;
                        row_pos   = 0;
                    end
                    CFG_HEIGHT:
                    begin
                        height_reg = cfg_data[15:0];
                        col_pos    = 0;
                        row_pos    = 0;
                    end
                    CFG_COEF0: coef_reg[0] = cfg_data;
                    CFG_COEF1: coef_reg[1] = cfg_data;
                    CFG_COEF2: coef_reg[2] = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                filter_pixel({blue_in, green_in, red_in});
            end
        end
    end

    // Compare each result transaction with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        filtered_pix_t e;
        if (!rst_n)
        begin
            errors = 0;
        end
        else if (out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("ERROR: unexpected result col=%0d row=%0d", out_col, out_row);
                end
            end
            else
            begin
                e = expected_pixels.pop_front();
                popped_count++;
                if (e.col !== out_col || e.row !== out_row || e.red !== red_out ||
                    e.green !== green_out || e.blue !== blue_out || e.last !== run_last)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("ERROR: expected col=%0d row=%0d rgb=%h/%h/%h last=%b",
                                 e.col, e.row, e.red, e.green, e.blue, e.last);
                        $display("       actual   col=%0d row=%0d rgb=%h/%h/%h last=%b",
                                 out_col, out_row, red_out, green_out, blue_out, run_last);
                    end
                end
            end
        end
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives frames of random and corner pixels through the RGB 3x3 convolution
// core under several geometries and masks, with random stalls on both
// sides, and reports the verdict of the scoreboard.
// ----------------------------------------------------------------------------
module testbench;
    import rkc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = CFG_WIDTH;
    logic [47:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  red_in = '0;
    logic [7:0]  green_in = '0;
    logic [7:0]  blue_in = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [9:0]  out_col;
    logic [15:0] out_row;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic        run_last;
    int          errors;
    int          pending;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    int          sent = 0;

    always #2 clk = ~clk;

    rgb_kernel_convolution_core DUT (.*);

    rkc_scoreboard u_scoreboard (.*);

    // Timeout guard.
    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: random stall bursts and one long hold-off on request.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
                @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                @(posedge clk);
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(input logic [47:0] w, input logic [47:0] h,
                             input logic [47:0] c0, input logic [47:0] c1,
                             input logic [47:0] c2);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_COEF0, c0);
        write_reg(CFG_COEF1, c1);
        write_reg(CFG_COEF2, c2);
    endtask

    // Offer one pixel transaction and hold it until accepted.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        in_valid <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        do @(posedge clk); while (in_stall);
        sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // Lower valid and let the pipeline empty before the next register write.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_coef;
        return ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600) - 300);
    endfunction

    function automatic logic [47:0] rand_group;
        return {rand_coef(), rand_coef(), rand_coef()};
    endfunction

    initial
    begin
        int w;
        int h;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full 3x3 frame with extreme coefficients: the last pixel emits nine.
        set_frame(48'd3, 48'd3, {16'h7FFF, 16'h8000, 16'h0100},
                  {16'h0100, 16'hFFFF, 16'h0080}, {16'h8000, 16'h7FFF, 16'h0001});
        for (int p = 0; p < 9; p++)
        begin
            send_pixel((p % 2) ? 8'hFF : 8'h00, (p % 3) ? 8'hFF : 8'h01, 8'($urandom));
        end
        drain();

        // Single-pixel and two-by-two frames, where windows are clipped.
        set_frame(48'd1, 48'd1, 48'h0000_0100_0000, 48'h0000_0100_0100, 48'h0100_0000_0100);
        for (int p = 0; p < 3; p++)
        begin
            send_pixel(8'($urandom), 8'($urandom), 8'hFF);
        end
        drain();
        set_frame(48'd2, 48'd2, 48'h0100_0100_0100, 48'h0100_0100_0100, 48'h0100_0100_0100);
        for (int p = 0; p < 4; p++)
        begin
            send_pixel(8'hFF, 8'h80, 8'h7F);
        end
        drain();

        // Zero geometry counts as one.
        set_frame(48'd0, 48'd0, 48'hFFFF_FFFF_FFFF, 48'h0200_0200_0200, 48'h0000_0000_0000);
        for (int p = 0; p < 2; p++)
        begin
            send_pixel(8'h40, 8'hC0, 8'h01);
        end
        drain();

        // Over-wide width saturates and the tallest height; no results yet.
        set_frame(48'd2047, 48'd65535, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                  48'hFFFF_FFFF_FFFF);
        for (int p = 0; p < 3; p++)
        begin
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end
        drain();

        // Random frames; the long hold-off falls on the second one.
        for (int f = 0; sent < 140; f++)
        begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            h = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
            set_frame(48'(w), 48'(h), rand_group(), rand_group(), rand_group());
            if (f == 1)
            begin
                hold_req = 1'b1;
            end
            if (sent > 100)
            begin
                quiet = 1'b1;
            end
            for (int p = 0; p < w * h; p++)
            begin
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            end
            drain();
        end

        if (errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
